// ===== hw/rtl/mps_pkg.sv =====
// Shared types and constants for the modem power sequencer.
// Holds word layouts, config register map and mode codes; no dependencies.
`timescale 1ns / 1ps

package mps_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int CFG_W              = 16;
  localparam int CFG_IDX_W          = 3;

  // Config register map
  localparam logic [CFG_IDX_W-1:0] REG_POWER_SETTLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_UP_DELAY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_DOWN_DELAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_OFF_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_TIMEOUT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHUTDOWN_TIMEOUT = 3'd5;

  localparam logic [CFG_W-1:0] DELAY_RESET   = 16'd100;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd30000;

  // Mode codes as seen on the result word
  localparam logic [2:0] MODE_CODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_CODE_STARTUP  = 3'd1;
  localparam logic [2:0] MODE_CODE_RUNNING  = 3'd2;
  localparam logic [2:0] MODE_CODE_SHUTDOWN = 3'd3;
  localparam logic [2:0] MODE_CODE_FAULT    = 3'd4;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_EARLY   = 2'd1;
  localparam logic [1:0] CAUSE_NO_RISE = 2'd2;
  localparam logic [1:0] CAUSE_NO_FALL = 2'd3;

  typedef struct packed {
    logic button_press;
    logic booted_level;
  } in_word_t;

  typedef struct packed {
    logic       power_enable;
    logic       modem_enable;
    logic       link_active;
    logic [2:0] mode_code;
    logic [1:0] fault_cause;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] power_settle_ms;
    logic [CFG_W-1:0] link_up_delay_ms;
    logic [CFG_W-1:0] link_down_delay_ms;
    logic [CFG_W-1:0] power_off_delay_ms;
    logic [CFG_W-1:0] boot_timeout_ms;
    logic [CFG_W-1:0] shutdown_timeout_ms;
  } cfg_regs_t;

endpackage

// ===== hw/rtl/modem_power_sequencer_core.sv =====
// Modem power sequencer, one tick word in, one status word out.
// A taken tick word is held in the tick register until the output stage is free; the step
// is one pass through mps_seq. Throughput: one tick word per cycle while no result word is held by out_stall.
// rst (synchronous) returns the sequencer to idle and the timing registers
// to their defaults; no clearing pass is needed.
// Depends on mps_pkg and mps_seq.
`timescale 1ns / 1ps

module modem_power_sequencer_core #(
  parameter int TIMER_BITS = mps_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mps_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mps_pkg::out_word_t             out_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mps_pkg::CFG_W-1:0]      cfg_data
);
  import mps_pkg::*;

  cfg_regs_t cfg;
  in_word_t  tick;
  logic      tick_valid;
  logic      adv;
  logic      step;
  logic      accept;

  assign cfg_ready = 1'b1;

  // output stage frees when empty or drained this cycle
  assign adv      = !out_valid || !out_stall;
  assign step     = tick_valid && adv;
  assign in_stall = tick_valid && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        tick_valid <= 1'b1;
      end else if (step) begin
        tick_valid <= 1'b0;
      end
      if (adv) begin
        out_valid <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tick <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.power_settle_ms     <= DELAY_RESET;
      cfg.link_up_delay_ms    <= DELAY_RESET;
      cfg.link_down_delay_ms  <= DELAY_RESET;
      cfg.power_off_delay_ms  <= DELAY_RESET;
      cfg.boot_timeout_ms     <= TIMEOUT_RESET;
      cfg.shutdown_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POWER_SETTLE:     cfg.power_settle_ms     <= cfg_data;
        REG_LINK_UP_DELAY:    cfg.link_up_delay_ms    <= cfg_data;
        REG_LINK_DOWN_DELAY:  cfg.link_down_delay_ms  <= cfg_data;
        REG_POWER_OFF_DELAY:  cfg.power_off_delay_ms  <= cfg_data;
        REG_BOOT_TIMEOUT:     cfg.boot_timeout_ms     <= cfg_data;
        REG_SHUTDOWN_TIMEOUT: cfg.shutdown_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  mps_seq #(
    .TIMER_BITS(TIMER_BITS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .tick   (tick),
    .cfg    (cfg),
    .result (out_word)
  );

`ifndef ASSERT_OFF
  // input side only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result word");

  // sequencer state moves only on a step
  a_hold_no_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(out_word))
    else $error("result word changed without a step");

  a_cause_in_fault: assert property (@(posedge clk) disable iff (rst)
    (out_word.fault_cause != CAUSE_NONE) |-> (out_word.mode_code == MODE_CODE_FAULT))
    else $error("fault cause set outside fault mode");

  a_link_powered: assert property (@(posedge clk) disable iff (rst)
    out_word.link_active |-> (out_word.power_enable && out_word.modem_enable))
    else $error("link up without power and enable");
`endif

endmodule

// ===== hw/rtl/mps_seq.sv =====
// Sequencer state and one-tick step logic for the modem power sequencer.
// Uses mps_pkg for word layouts, config struct and mode codes.
`timescale 1ns / 1ps

module mps_seq #(
  parameter int TIMER_BITS = mps_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  mps_pkg::in_word_t   tick,
  input  mps_pkg::cfg_regs_t  cfg,
  output mps_pkg::out_word_t  result
);
  import mps_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

  typedef enum logic [2:0] {
    IDLE     = MODE_CODE_IDLE,
    STARTUP  = MODE_CODE_STARTUP,
    RUNNING  = MODE_CODE_RUNNING,
    SHUTDOWN = MODE_CODE_SHUTDOWN,
    FAULT    = MODE_CODE_FAULT
  } mode_t;

  typedef enum logic [1:0] {
    SUB_ACTION = 2'd0,
    SUB_WAIT   = 2'd1,
    SUB_DELAY  = 2'd2
  } sub_t;

  mode_t                 mode, mode_next;
  sub_t                  sub_phase, sub_phase_next;
  logic [TIMER_BITS-1:0] phase_elapsed, phase_elapsed_next;
  logic                  supply_on, supply_on_next;
  logic                  enable_high, enable_high_next;
  logic                  link_on, link_on_next;
  logic [1:0]            last_fault, last_fault_next;

  logic [TIMER_BITS-1:0] k;
  logic [CMP_W-1:0]      k_ext;
  logic                  hit_settle, hit_up, hit_down, hit_off, hit_boot, hit_shut;

  // saturating tick count, then compare against the thresholds
  assign k     = (&phase_elapsed) ? phase_elapsed : phase_elapsed + TIMER_BITS'(1);
  assign k_ext = CMP_W'(k);

  assign hit_settle = k_ext >= CMP_W'(cfg.power_settle_ms);
  assign hit_up     = k_ext >= CMP_W'(cfg.link_up_delay_ms);
  assign hit_down   = k_ext >= CMP_W'(cfg.link_down_delay_ms);
  assign hit_off    = k_ext >= CMP_W'(cfg.power_off_delay_ms);
  assign hit_boot   = k_ext >= CMP_W'(cfg.boot_timeout_ms);
  assign hit_shut   = k_ext >= CMP_W'(cfg.shutdown_timeout_ms);

  always_comb begin
    mode_next          = mode;
    sub_phase_next     = sub_phase;
    phase_elapsed_next = k;
    supply_on_next     = supply_on;
    enable_high_next   = enable_high;
    link_on_next       = link_on;
    last_fault_next    = last_fault;

    unique case (mode)
      IDLE: begin
        if (tick.button_press) begin
          supply_on_next     = 1'b1;
          mode_next          = STARTUP;
          sub_phase_next     = SUB_ACTION;
          phase_elapsed_next = '0;
        end
      end
      STARTUP: begin
        unique case (sub_phase)
          SUB_ACTION: begin
            if (hit_settle) begin
              if (tick.booted_level) begin
                supply_on_next  = 1'b0;
                link_on_next    = 1'b0;
                last_fault_next = CAUSE_EARLY;
                mode_next       = FAULT;
                sub_phase_next  = SUB_ACTION;
              end else begin
                enable_high_next = 1'b1;
                sub_phase_next   = SUB_WAIT;
              end
              phase_elapsed_next = '0;
            end
          end
          SUB_WAIT: begin
            if (tick.booted_level) begin
              sub_phase_next     = SUB_DELAY;
              phase_elapsed_next = '0;
            end else if (hit_boot) begin
              supply_on_next     = 1'b0;
              link_on_next       = 1'b0;
              last_fault_next    = CAUSE_NO_RISE;
              mode_next          = FAULT;
              sub_phase_next     = SUB_ACTION;
              phase_elapsed_next = '0;
            end
          end
          default: begin
            if (hit_up) begin
              link_on_next       = 1'b1;
              mode_next          = RUNNING;
              sub_phase_next     = SUB_ACTION;
              phase_elapsed_next = '0;
            end
          end
        endcase
      end
      RUNNING: begin
        if (tick.button_press) begin
          link_on_next       = 1'b0;
          mode_next          = SHUTDOWN;
          sub_phase_next     = SUB_ACTION;
          phase_elapsed_next = '0;
        end
      end
      SHUTDOWN: begin
        unique case (sub_phase)
          SUB_ACTION: begin
            if (hit_down) begin
              enable_high_next   = 1'b0;
              sub_phase_next     = SUB_WAIT;
              phase_elapsed_next = '0;
            end
          end
          SUB_WAIT: begin
            if (!tick.booted_level) begin
              sub_phase_next     = SUB_DELAY;
              phase_elapsed_next = '0;
            end else if (hit_shut) begin
              supply_on_next     = 1'b0;
              link_on_next       = 1'b0;
              last_fault_next    = CAUSE_NO_FALL;
              mode_next          = FAULT;
              sub_phase_next     = SUB_ACTION;
              phase_elapsed_next = '0;
            end
          end
          default: begin
            if (hit_off) begin
              supply_on_next     = 1'b0;
              mode_next          = IDLE;
              sub_phase_next     = SUB_ACTION;
              phase_elapsed_next = '0;
            end
          end
        endcase
      end
      default: begin
        // fault: enable follows booted low; a press then acknowledges
        if (!tick.booted_level) begin
          enable_high_next = 1'b0;
          if (tick.button_press) begin
            last_fault_next    = CAUSE_NONE;
            mode_next          = IDLE;
            sub_phase_next     = SUB_ACTION;
            phase_elapsed_next = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= IDLE;
      sub_phase     <= SUB_ACTION;
      phase_elapsed <= '0;
      supply_on     <= 1'b0;
      enable_high   <= 1'b0;
      link_on       <= 1'b0;
      last_fault    <= CAUSE_NONE;
    end else if (step) begin
      mode          <= mode_next;
      sub_phase     <= sub_phase_next;
      phase_elapsed <= phase_elapsed_next;
      supply_on     <= supply_on_next;
      enable_high   <= enable_high_next;
      link_on       <= link_on_next;
      last_fault    <= last_fault_next;
    end
  end

  assign result.power_enable = supply_on;
  assign result.modem_enable = enable_high;
  assign result.link_active  = link_on;
  assign result.mode_code    = mode;
  assign result.fault_cause  = last_fault;

endmodule
